// ===== rtl/core/dssr_pkg.sv =====
// Shared constants and types of the dual scale serial reader.
package dssr_pkg;

    // Defaults of the top level parameters
    localparam int FRAME_TICKS_DEF = 200;
    localparam int WORD_BITS_DEF   = 21;

    // Fixed field widths
    localparam int TICK_W      = 8;
    localparam int POS_W       = 26;
    localparam int RAW_W       = 21;
    localparam int ZERO_W      = 25;
    localparam int LIMIT_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 96;

    // Settle limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd5;

    // Phase of a tick inside its group of four
    typedef enum logic [1:0] {
        PH_RISE   = 2'd0,
        PH_SAMPLE = 2'd1,
        PH_IDLE   = 2'd2,
        PH_EVENT  = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ZERO = 2'd0,
        CFG_Z_ZERO = 2'd1,
        CFG_LIMIT  = 2'd2
    } t_cfg_idx;

endpackage

// ===== rtl/core/dssr_axis.sv =====
// Position update of one scale axis: settle check and raw*10 - zero.
module dssr_axis
    import dssr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_prev,
    input  logic [ZERO_W-1:0]    i_zero,
    input  logic [LIMIT_W-1:0]   i_limit,
    input  logic [POS_W-1:0]     i_pos,
    output logic [POS_W-1:0]     o_pos
);

    localparam int DIFF_W = WORD_BITS + 1;
    localparam int CMP_W  = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;

    logic signed [POS_W-1:0]  raw_ext;
    logic signed [POS_W-1:0]  zero_ext;
    logic signed [POS_W-1:0]  scaled;
    logic signed [POS_W-1:0]  pos_new;
    logic signed [DIFF_W-1:0] word_d;
    logic signed [DIFF_W-1:0] prev_d;
    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] mag;
    logic        [CMP_W-1:0]  mag_c;
    logic        [CMP_W-1:0]  limit_c;

    always_comb begin
        raw_ext  = $signed({{(POS_W-WORD_BITS){i_word[WORD_BITS-1]}}, i_word});
        zero_ext = $signed({{(POS_W-ZERO_W){i_zero[ZERO_W-1]}}, i_zero});
        // times ten as 8x + 2x, wrapping at the position width
        scaled   = (raw_ext <<< 3) + (raw_ext <<< 1);
        pos_new  = scaled - zero_ext;

        word_d   = $signed({i_word[WORD_BITS-1], i_word});
        prev_d   = $signed({i_prev[WORD_BITS-1], i_prev});
        diff     = prev_d - word_d;
        mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag_c    = CMP_W'(mag);
        limit_c  = CMP_W'(i_limit);

        // accept the reading only when it moved less than the limit
        o_pos = (mag_c < limit_c) ? POS_W'(pos_new) : i_pos;
    end

endmodule

// ===== rtl/core/dual_scale_serial_reader.sv =====
// Top level of the dual scale serial reader: tick sequencer, shift registers, output stage.
//
// Every input word is one timer tick carrying the sampled data lines of the X and Z
// scales; every accepted tick yields exactly one registered output word,
// and a new tick is taken in every cycle (one tick per clock sustained) as long as the
// output side keeps up. The rate is set by the single output register: the whole tick
// update (phase decode, shift, latch, settle check, raw*10 - zero) is done between the
// state registers and that register, and a full output register still takes a tick in
// the cycle its word is taken. Within a frame of FRAME_TICKS ticks each group of four
// ticks raises the shared scale clock, samples both lines and lowers the clock, then
// handles frame events. WORD_BITS bits arrive LSB first, the last one the sign; at the
// tick 4*WORD_BITS-1 the words latch, frame_done is flagged and each position takes
// raw*10 - zero only when the raw word moved less than settle_limit from the previous
// frame. At the frame end the latched words become the previous ones and the shift
// registers clear. Configuration writes land in one cycle and must be made while idle.
module dual_scale_serial_reader
    import dssr_pkg::*;
#(
    parameter int FRAME_TICKS = FRAME_TICKS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // tick input
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // x_data[0], z_data[1], zero pad

    // result output
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // scale_clock[0], x_position[26:1],
                                                // z_position[52:27], x_raw[73:53],
                                                // z_raw[94:74], zero pad
    output logic [0:0]             o_m_tuser    // frame_done[0]
);

    localparam int TICK_NW = TICK_W + 1;
    localparam logic [TICK_NW-1:0] LATCH_TICK = TICK_NW'(4 * WORD_BITS);
    localparam logic [TICK_NW-1:0] END_TICK   = TICK_NW'(FRAME_TICKS);

    // configuration
    logic [ZERO_W-1:0]    r_x_zero;
    logic [ZERO_W-1:0]    r_z_zero;
    logic [LIMIT_W-1:0]   r_limit;

    // tick state
    logic [TICK_W-1:0]    r_tick,      n_tick;
    logic                 r_paused,    n_paused;
    logic                 r_clk,       n_clk;
    logic [WORD_BITS-1:0] r_x_shift,   n_x_shift;
    logic [WORD_BITS-1:0] r_z_shift,   n_z_shift;
    logic [WORD_BITS-1:0] r_x_latched, n_x_latched;
    logic [WORD_BITS-1:0] r_z_latched, n_z_latched;
    logic [WORD_BITS-1:0] r_x_prev,    n_x_prev;
    logic [WORD_BITS-1:0] r_z_prev,    n_z_prev;
    logic [POS_W-1:0]     r_x_pos,     n_x_pos;
    logic [POS_W-1:0]     r_z_pos,     n_z_pos;
    logic                 n_done;

    // output stage
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_done;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic                 in_fire;
    logic [TICK_NW-1:0]   tick_next;
    logic                 x_bit;
    logic                 z_bit;
    logic [POS_W-1:0]     x_upd_pos;
    logic [POS_W-1:0]     z_upd_pos;
    logic [POS_W-1:0]     x_raw_ext;
    logic [POS_W-1:0]     z_raw_ext;

    // take a tick whenever the output register is free or drains this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign x_bit = i_s_tdata[0];
    assign z_bit = i_s_tdata[1];

    // candidate positions from the words that would latch on this tick
    dssr_axis #(.WORD_BITS(WORD_BITS)) u_x_axis (
        .i_word  (r_x_shift),
        .i_prev  (r_x_prev),
        .i_zero  (r_x_zero),
        .i_limit (r_limit),
        .i_pos   (r_x_pos),
        .o_pos   (x_upd_pos)
    );

    dssr_axis #(.WORD_BITS(WORD_BITS)) u_z_axis (
        .i_word  (r_z_shift),
        .i_prev  (r_z_prev),
        .i_zero  (r_z_zero),
        .i_limit (r_limit),
        .i_pos   (r_z_pos),
        .o_pos   (z_upd_pos)
    );

    always_comb begin
        n_paused    = r_paused;
        n_clk       = r_clk;
        n_x_shift   = r_x_shift;
        n_z_shift   = r_z_shift;
        n_x_latched = r_x_latched;
        n_z_latched = r_z_latched;
        n_x_prev    = r_x_prev;
        n_z_prev    = r_z_prev;
        n_x_pos     = r_x_pos;
        n_z_pos     = r_z_pos;
        n_done      = 1'b0;
        tick_next   = {1'b0, r_tick} + TICK_NW'(1);

        unique case (t_phase'(r_tick[1:0]))
            PH_RISE: begin
                if (!r_paused) n_clk = 1'b1;
            end
            PH_SAMPLE: begin
                // shift in LSB first, lower the scale clock
                if (!r_paused) begin
                    n_x_shift = {x_bit, r_x_shift[WORD_BITS-1:1]};
                    n_z_shift = {z_bit, r_z_shift[WORD_BITS-1:1]};
                    n_clk     = 1'b0;
                end
            end
            PH_IDLE: begin
            end
            PH_EVENT: begin
                // latch the words, hold the clock for the rest of the frame
                if (tick_next == LATCH_TICK) begin
                    n_x_latched = r_x_shift;
                    n_z_latched = r_z_shift;
                    n_paused    = 1'b1;
                    n_done      = 1'b1;
                    n_x_pos     = x_upd_pos;
                    n_z_pos     = z_upd_pos;
                end
                // frame end: keep the words for the settle check, restart
                if (tick_next >= END_TICK) begin
                    n_x_prev  = n_x_latched;
                    n_z_prev  = n_z_latched;
                    n_x_shift = '0;
                    n_z_shift = '0;
                    n_paused  = 1'b0;
                    tick_next = '0;
                end
            end
        endcase

        n_tick = tick_next[TICK_W-1:0];

        x_raw_ext  = {{(POS_W-WORD_BITS){n_x_latched[WORD_BITS-1]}}, n_x_latched};
        z_raw_ext  = {{(POS_W-WORD_BITS){n_z_latched[WORD_BITS-1]}}, n_z_latched};
        n_out_data = {1'b0, z_raw_ext[RAW_W-1:0], x_raw_ext[RAW_W-1:0],
                      n_z_pos, n_x_pos, n_clk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_zero <= '0;
            r_z_zero <= '0;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_ZERO: r_x_zero <= i_cfg_wdata[ZERO_W-1:0];
                CFG_Z_ZERO: r_z_zero <= i_cfg_wdata[ZERO_W-1:0];
                CFG_LIMIT:  r_limit  <= i_cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_paused    <= 1'b0;
            r_clk       <= 1'b0;
            r_x_shift   <= '0;
            r_z_shift   <= '0;
            r_x_latched <= '0;
            r_z_latched <= '0;
            r_x_prev    <= '0;
            r_z_prev    <= '0;
            r_x_pos     <= '0;
            r_z_pos     <= '0;
        end else if (in_fire) begin
            r_tick      <= n_tick;
            r_paused    <= n_paused;
            r_clk       <= n_clk;
            r_x_shift   <= n_x_shift;
            r_z_shift   <= n_z_shift;
            r_x_latched <= n_x_latched;
            r_z_latched <= n_z_latched;
            r_x_prev    <= n_x_prev;
            r_z_prev    <= n_z_prev;
            r_x_pos     <= n_x_pos;
            r_z_pos     <= n_z_pos;
        end
    end

    // output register: valid is control, the word itself needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
            r_out_done <= n_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_done;

endmodule

// ===== test/dual_scale_serial_reader_check.sv =====
// Checker for the dual scale serial reader: tracks the tick sequencer and compares every result word.
`timescale 1ns / 1ps
module dual_scale_serial_reader_check
    import dssr_pkg::*;
#(
    parameter int FRAME_TICKS = FRAME_TICKS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // x_data[0], z_data[1], zero pad
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,   // scale_clock[0], x_position[26:1],
                                                // z_position[52:27], x_raw[73:53],
                                                // z_raw[94:74], zero pad
    input  logic [0:0]             i_m_tuser,   // frame_done[0]
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct {
        logic             scale_clock;
        logic [POS_W-1:0] x_position;
        logic [POS_W-1:0] z_position;
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] z_raw;
        logic             frame_done;
    } t_readout;

    logic [ZERO_W-1:0]  x_zero, z_zero;
    logic [LIMIT_W-1:0] settle_limit;
    logic [TICK_W-1:0]  tick;
    logic               paused, clk_level;
    logic [RAW_W-1:0]   x_shift, z_shift, x_word, z_word, x_prev, z_prev;
    logic [POS_W-1:0]   x_pos, z_pos;

    t_readout pending_readouts[$];
    int       mismatches = 0;

    // signed value of a scale word of WORD_BITS bits
    function automatic longint word_value(logic [RAW_W-1:0] w);
        longint v;
        v = longint'(w) & ((longint'(1) << WORD_BITS) - 1);
        if (v[WORD_BITS-1])
            v -= longint'(1) << WORD_BITS;
        return v;
    endfunction

    // take raw*10 - zero only when the word moved less than the settle limit
    function automatic logic [POS_W-1:0] settle(logic [POS_W-1:0] pos, logic [RAW_W-1:0] word,
                                               logic [RAW_W-1:0] prev, logic [ZERO_W-1:0] zero);
        longint raw, change;
        raw    = word_value(word);
        change = word_value(prev) - raw;
        if (change < 0)
            change = -change;
        if (change < longint'(settle_limit))
            pos = POS_W'(raw * 10 - longint'($signed(zero)));
        return pos;
    endfunction

    function automatic t_readout advance_tick(logic x_bit, logic z_bit);
        t_readout r;
        int       nxt;
        nxt          = int'(tick) + 1;
        r.frame_done = 1'b0;
        case (t_phase'(tick[1:0]))
            PH_RISE: begin
                if (!paused)
                    clk_level = 1'b1;
            end
            PH_SAMPLE: begin
                if (!paused) begin
                    x_shift   = (x_shift >> 1) | (RAW_W'(x_bit) << (WORD_BITS - 1));
                    z_shift   = (z_shift >> 1) | (RAW_W'(z_bit) << (WORD_BITS - 1));
                    clk_level = 1'b0;
                end
            end
            PH_IDLE: ;
            PH_EVENT: begin
                if (nxt == 4 * WORD_BITS) begin
                    x_word       = x_shift;
                    z_word       = z_shift;
                    paused       = 1'b1;
                    r.frame_done = 1'b1;
                    x_pos        = settle(x_pos, x_word, x_prev, x_zero);
                    z_pos        = settle(z_pos, z_word, z_prev, z_zero);
                end
                if (nxt >= FRAME_TICKS) begin
                    x_prev  = x_word;
                    z_prev  = z_word;
                    x_shift = '0;
                    z_shift = '0;
                    paused  = 1'b0;
                    nxt     = 0;
                end
            end
        endcase
        tick          = TICK_W'(nxt);
        r.scale_clock = clk_level;
        r.x_position  = x_pos;
        r.z_position  = z_pos;
        r.x_raw       = RAW_W'(word_value(x_word));
        r.z_raw       = RAW_W'(word_value(z_word));
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_readout want;
        if (!i_rst_n) begin
            x_zero       = '0;
            z_zero       = '0;
            settle_limit = LIMIT_RESET;
            tick         = '0;
            paused       = 1'b0;
            clk_level    = 1'b0;
            x_shift      = '0;
            z_shift      = '0;
            x_word       = '0;
            z_word       = '0;
            x_prev       = '0;
            z_prev       = '0;
            x_pos        = '0;
            z_pos        = '0;
            pending_readouts.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_X_ZERO: x_zero       = i_cfg_wdata[ZERO_W-1:0];
                    CFG_Z_ZERO: z_zero       = i_cfg_wdata[ZERO_W-1:0];
                    CFG_LIMIT:  settle_limit = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing: a result never belongs to the tick taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (pending_readouts.size() == 0) begin
                    $error("result word with no tick pending");
                    mismatches++;
                end else begin
                    want = pending_readouts.pop_front();
                    check_field("scale_clock", longint'(want.scale_clock),
                                longint'(i_m_tdata[0]));
                    check_field("x_position", longint'($signed(want.x_position)),
                                longint'($signed(i_m_tdata[POS_W:1])));
                    check_field("z_position", longint'($signed(want.z_position)),
                                longint'($signed(i_m_tdata[2*POS_W:POS_W+1])));
                    check_field("x_raw", longint'($signed(want.x_raw)),
                                longint'($signed(i_m_tdata[2*POS_W+RAW_W:2*POS_W+1])));
                    check_field("z_raw", longint'($signed(want.z_raw)),
                                longint'($signed(i_m_tdata[2*POS_W+2*RAW_W:2*POS_W+RAW_W+1])));
                    check_field("frame_done", longint'(want.frame_done),
                                longint'(i_m_tuser[0]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_readouts.push_back(advance_tick(i_s_tdata[0], i_s_tdata[1]));
        end
        o_mismatches <= mismatches;
        o_pending    <= pending_readouts.size();
    end

endmodule

// ===== test/dual_scale_serial_reader_test.sv =====
// Testbench top of the dual scale serial reader: tick stimulus, result sink and verdict.
`timescale 1ns / 1ps
module dual_scale_serial_reader_test;
    import dssr_pkg::*;

    localparam int FRAMES          = 11;       // four directed frames, the rest random
    localparam int LONG_HOLD       = 300;      // sink hold-off, long enough to back up the input
    localparam int STALL_LIMIT     = 3000;     // cycles without any word moving
    localparam int DRAIN_CYCLES    = 8;
    localparam int ZERO_MIN        = -10485760;
    localparam int ZERO_MAX        = 10485750;
    localparam int LIMIT_MAX       = 1048575;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind this index
    localparam logic [RAW_W-1:0] WORD_MAX = 21'h0F_FFFF;
    localparam logic [RAW_W-1:0] WORD_MIN = 21'h10_0000;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;   // x_data[0], z_data[1], zero pad
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // scale_clock[0], x_position[26:1],
                                                // z_position[52:27], x_raw[73:53],
                                                // z_raw[94:74], zero pad
    logic [0:0]             o_m_tuser;          // frame_done[0]

    int mismatches;
    int readouts_pending;
    int idle_cycles = 0;

    // set by the tick source; the sink reads the first two
    bit               rx_eager      = 1'b0;   // sink takes every word without stalling
    bit               long_hold_req = 1'b0;   // sink serves one long hold-off of LONG_HOLD at its next draw
    logic [LIMIT_W-1:0] cur_limit   = LIMIT_RESET;
    logic [RAW_W-1:0]   last_x      = '0;     // words sent in the previous frame
    logic [RAW_W-1:0]   last_z      = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    dual_scale_serial_reader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    dual_scale_serial_reader_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_mismatches (mismatches),
        .o_pending    (readouts_pending)
    );

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge i_clk)
        idle_cycles <= ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) ?
                       0 : idle_cycles + 1;

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Result sink: draw a stall before every word, or take words back to back
    // while rx_eager is set. A pending long hold-off is served at the next draw.
    initial begin : sink
        int hold;
        forever begin
            hold = rx_eager ? 0 : $urandom_range(0, 10);
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            repeat (hold) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Offer one tick after an optional gap and hold it until taken. tvalid stays
    // high on return so back-to-back ticks need no extra assignment.
    task automatic send_tick(logic x_bit, logic z_bit, int gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'({z_bit, x_bit});
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    // Stop offering and wait until every expected result word has been taken.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (readouts_pending != 0);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Write all three registers plus a throwaway write to the unused index.
    // Call only while the block is idle.
    task automatic apply_setting(logic [ZERO_W-1:0] x_zero, logic [ZERO_W-1:0] z_zero,
                                 logic [LIMIT_W-1:0] limit);
        write_reg(CFG_X_ZERO, CFG_DATA_W'(x_zero));
        write_reg(CFG_Z_ZERO, CFG_DATA_W'(z_zero));
        write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
        cur_limit = limit;
    endtask

    // Drive one full frame. The word bits go out LSB first on the sample ticks
    // (phase 1 of the first WORD_BITS groups); every other tick carries random
    // line levels, which the block must ignore. A pause_at inside the frame makes
    // the source stop there until all results are back.
    task automatic send_frame(logic [RAW_W-1:0] x_word, logic [RAW_W-1:0] z_word,
                              bit paced, int pause_at);
        logic x_bit, z_bit;
        for (int t = 0; t < FRAME_TICKS_DEF; t++) begin
            x_bit = 1'($urandom_range(0, 1));
            z_bit = 1'($urandom_range(0, 1));
            if (t % 4 == int'(PH_SAMPLE) && t / 4 < WORD_BITS_DEF) begin
                x_bit = x_word[t/4];
                z_bit = z_word[t/4];
            end
            if (t == pause_at)
                drain();
            send_tick(x_bit, z_bit, paced ? $urandom_range(0, 10) : 0);
        end
        last_x = x_word;
        last_z = z_word;
    endtask

    // Mostly a small move around the previous word, reaching just past the
    // settle limit on both sides; sometimes a jump anywhere.
    function automatic logic [RAW_W-1:0] next_word(logic [RAW_W-1:0] prev);
        int span;
        if ($urandom_range(0, 9) < 3)
            return RAW_W'($urandom);
        span = int'(cur_limit) + 1;
        return RAW_W'(int'(prev) + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [ZERO_W-1:0] random_zero();
        return ZERO_W'(int'($urandom_range(0, ZERO_MAX - ZERO_MIN)) + ZERO_MIN);
    endfunction

    initial begin : stimulus
        logic [LIMIT_W-1:0] limit;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first frame on reset settings: previous words are zero, small move accepted
        send_frame(RAW_W'(3), RAW_W'(-4), 1'b0, -1);

        // extreme offsets, widest limit, words at both ends of the range
        drain();
        apply_setting(ZERO_W'(ZERO_MIN), ZERO_W'(ZERO_MAX), LIMIT_W'(LIMIT_MAX));
        send_frame(WORD_MAX, WORD_MIN, 1'b1, -1);

        // full-scale swing in the other direction: rejected, raw still latches;
        // the source also stops mid-frame until everything is back
        drain();
        send_frame(WORD_MIN, WORD_MAX, 1'b1, 100);

        // zero limit rejects even an unchanged word
        drain();
        apply_setting(ZERO_W'(ZERO_MAX), ZERO_W'(ZERO_MIN), '0);
        send_frame(WORD_MIN, WORD_MAX, 1'b1, -1);

        for (int f = 4; f < FRAMES; f++) begin
            rx_eager = ($urandom_range(0, 3) == 0);
            // back the block up once while the source keeps offering
            if (f == 6)
                long_hold_req = 1'b1;
            if (f == 4 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       limit = LIMIT_W'($urandom_range(0, 8));
                    1:       limit = LIMIT_W'($urandom_range(0, 1000));
                    2:       limit = LIMIT_W'($urandom_range(0, LIMIT_MAX));
                    default: limit = LIMIT_W'(LIMIT_MAX);
                endcase
                drain();
                apply_setting(random_zero(), random_zero(), limit);
            end
            send_frame(next_word(last_x), next_word(last_z), $urandom_range(0, 3) != 0,
                       ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 199)) : -1);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dssr_pkg.sv
rtl/core/dssr_axis.sv
rtl/core/dual_scale_serial_reader.sv
test/dual_scale_serial_reader_check.sv
test/dual_scale_serial_reader_test.sv
